// ===== hw/rtl/qftv_pkg.sv =====
// Shared types, constants and the arctangent table for the shortest-arc
// quaternion unit. No dependencies.
`default_nettype none

package qftv_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int SQ_CELLS      = 32;
  localparam int DIV_CELLS     = 32;
  localparam int XW            = 34;
  localparam int ZW            = 36;

  typedef logic signed [XW-1:0] xy_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic [63:0]          wide_t;
  typedef logic [DIV_CELLS-1:0] quo_t;
  typedef logic [4:0]           idx_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_IDENT  = 2'd1,
    ST_DEGEN  = 2'd2
  } status_t;

  localparam ang_t HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [15:0] W_ONE = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

  function automatic ang_t atan_q30(input idx_t k);
    ang_t a;
    case (k)
      5'd0:  a = 36'sd843314857;
      5'd1:  a = 36'sd497837829;
      5'd2:  a = 36'sd263043837;
      5'd3:  a = 36'sd133525159;
      5'd4:  a = 36'sd67021687;
      5'd5:  a = 36'sd33543516;
      5'd6:  a = 36'sd16775851;
      5'd7:  a = 36'sd8388437;
      5'd8:  a = 36'sd4194283;
      5'd9:  a = 36'sd2097149;
      5'd10: a = 36'sd1048576;
      5'd11: a = 36'sd524288;
      5'd12: a = 36'sd262144;
      5'd13: a = 36'sd131072;
      5'd14: a = 36'sd65536;
      5'd15: a = 36'sd32768;
      5'd16: a = 36'sd16384;
      5'd17: a = 36'sd8192;
      5'd18: a = 36'sd4096;
      5'd19: a = 36'sd2048;
      5'd20: a = 36'sd1024;
      5'd21: a = 36'sd512;
      5'd22: a = 36'sd256;
      5'd23: a = 36'sd128;
      5'd24: a = 36'sd64;
      5'd25: a = 36'sd32;
      5'd26: a = 36'sd16;
      5'd27: a = 36'sd8;
      5'd28: a = 36'sd4;
      5'd29: a = 36'sd2;
      5'd30: a = 36'sd1;
      default: a = 36'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qftv_sqrt_cell.sv =====
// One step of the integer square root: settles one root bit per cell.
// Depends on qftv_pkg.
`default_nettype none

module qftv_sqrt_cell (
  input  wire               clk,
  input  wire               en,
  input  qftv_pkg::idx_t    j,
  input  qftv_pkg::wide_t   v_i,
  input  qftv_pkg::wide_t   r_i,
  output qftv_pkg::wide_t   v_o,
  output qftv_pkg::wide_t   r_o
);
  import qftv_pkg::*;

  wide_t       b;
  logic [64:0] t;
  logic        ge;
  wide_t       v_nxt, r_nxt, v_r, r_r;

  always_comb begin
    b     = 64'd1 << {j, 1'b0};
    t     = {1'b0, r_i} + {1'b0, b};
    ge    = {1'b0, v_i} >= t;
    v_nxt = ge ? (v_i - t[63:0]) : v_i;
    r_nxt = ge ? ((r_i >> 1) + b) : (r_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;

endmodule

`default_nettype wire

// ===== hw/rtl/qftv_cordic_cell.sv =====
// One CORDIC micro-rotation, vectoring or rotation mode.
// Depends on qftv_pkg for widths and the arctangent table.
`default_nettype none

module qftv_cordic_cell (
  input  wire              clk,
  input  wire              en,
  input  wire              rot,
  input  qftv_pkg::idx_t   k,
  input  qftv_pkg::xy_t    x_i,
  input  qftv_pkg::xy_t    y_i,
  input  qftv_pkg::ang_t   z_i,
  output qftv_pkg::xy_t    x_o,
  output qftv_pkg::xy_t    y_o,
  output qftv_pkg::ang_t   z_o
);
  import qftv_pkg::*;

  xy_t  xs, ys, x_nxt, y_nxt, x_r, y_r;
  ang_t a, z_nxt, z_r;
  logic pos, s_up;

  always_comb begin
    xs    = x_i >>> k;
    ys    = y_i >>> k;
    a     = atan_q30(k);
    pos   = rot ? !z_i[ZW-1] : !y_i[XW-1];
    s_up  = rot ? pos : !pos;
    x_nxt = s_up ? (x_i - ys) : (x_i + ys);
    y_nxt = s_up ? (y_i + xs) : (y_i - xs);
    z_nxt = s_up ? (z_i - a) : (z_i + a);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

`default_nettype wire

// ===== hw/rtl/qftv_div_cell.sv =====
// One step of restoring division: settles one quotient bit per cell.
// Depends on qftv_pkg.
`default_nettype none

module qftv_div_cell (
  input  wire               clk,
  input  wire               en,
  input  qftv_pkg::idx_t    j,
  input  qftv_pkg::wide_t   rem_i,
  input  qftv_pkg::wide_t   den_i,
  input  qftv_pkg::quo_t    q_i,
  output qftv_pkg::wide_t   rem_o,
  output qftv_pkg::wide_t   den_o,
  output qftv_pkg::quo_t    q_o
);
  import qftv_pkg::*;

  logic [95:0] trial;
  logic        ge;
  wide_t       rem_nxt, rem_r, den_r;
  quo_t        q_nxt, q_r;

  always_comb begin
    trial   = {32'd0, den_i} << j;
    ge      = {32'd0, rem_i} >= trial;
    rem_nxt = ge ? (rem_i - trial[63:0]) : rem_i;
    q_nxt   = {q_i[DIV_CELLS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_from_two_vectors_unit.sv =====
// Shortest-arc rotation quaternion between two Q1.14 vectors.
// Depends on qftv_pkg, qftv_sqrt_cell, qftv_cordic_cell, qftv_div_cell.
//
// Input channel: in_valid/in_stall carry src and dst vectors; a transfer
// happens at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall carry quat_w/x/y/z and status
// (0 normal, 1 identical vectors, 2 zero cross product, axis zeroed).
// Throughput: one item per cycle unless a held result stalls the chain.
// From input transfer to result transfer an item passes through 4 product
// stages, 32 root cells for the dot-product sine and the cross-product norm,
// 16 vectoring and 16 rotation CORDIC cells, 3 magnitude stages, 32 root
// cells, 1 rounding stage, 32 divider cells for w and the sine, 2 scaling
// stages, 32 divider cells for the axis, and the output register.
// Reset clears all valid flags; no results are pending after reset.
// When out_valid is high and out_stall is high, the whole chain holds and
// in_stall rises; the held result stays unchanged until it transfers.
`default_nettype none

module quaternion_from_two_vectors_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [15:0]  in_src_x,
  input  wire signed [15:0]  in_src_y,
  input  wire signed [15:0]  in_src_z,
  input  wire signed [15:0]  in_dst_x,
  input  wire signed [15:0]  in_dst_y,
  input  wire signed [15:0]  in_dst_z,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic [1:0]         out_status
);
  import qftv_pkg::*;

  localparam int ST_S1  = 0;
  localparam int ST_S2  = 1;
  localparam int ST_S3  = 2;
  localparam int ST_S4  = ST_S3 + 1;
  localparam int SQA0   = ST_S4 + 1;
  localparam int VEC0   = SQA0 + SQ_CELLS;
  localparam int ROT0   = VEC0 + CORDIC_STAGES;
  localparam int ST_M1  = ROT0 + CORDIC_STAGES;
  localparam int ST_M2  = ST_M1 + 1;
  localparam int ST_M3  = ST_M2 + 1;
  localparam int SQB0   = ST_M3 + 1;
  localparam int ST_D0  = SQB0 + SQ_CELLS;
  localparam int DVC0   = ST_D0 + 1;
  localparam int ST_E1  = DVC0 + DIV_CELLS;
  localparam int ST_E2  = ST_E1 + 1;
  localparam int DVD0   = ST_E2 + 1;
  localparam int ST_OUT = DVD0 + DIV_CELLS;
  localparam int DEPTH  = ST_OUT + 1;

  localparam int PSH_R = (2 * FRAC_BITS >= 30) ? (2 * FRAC_BITS - 30) : 0;
  localparam int PSH_L = (2 * FRAC_BITS >= 30) ? 0 : (30 - 2 * FRAC_BITS);
  localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);

  typedef struct packed {
    logic             eq;
    logic [2:0]       csgn;
    logic [2:0][31:0] ca;
    logic             psgn;
    logic [30:0]      pa;
    logic [31:0]      norm;
    logic             xsgn;
    logic             ysgn;
    logic [31:0]      ax;
    logic [31:0]      ay;
    logic [15:0]      w;
  } side_t;

  function automatic logic [15:0] sat16(input logic [31:0] m, input logic neg);
    logic [31:0] mn;
    mn = -m;
    if (neg) begin
      return (m > 32'd32768) ? 16'h8000 : mn[15:0];
    end
    return (m > 32'd32767) ? 16'h7fff : m[15:0];
  endfunction

  logic adv;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  side_t side_r [DEPTH];
  side_t side_nxt [DEPTH];

  assign adv      = !(vld_r[ST_OUT] && out_stall);
  assign in_stall = !adv;

  // stage S1: cross and dot products
  logic signed [31:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx, m_xx, m_yy, m_zz;
  logic signed [32:0] cx_nxt, cy_nxt, cz_nxt, cx_r, cy_r, cz_r;
  logic signed [33:0] p_nxt, p_r;

  always_comb begin
    m_yz   = in_src_y * in_dst_z;
    m_zy   = in_src_z * in_dst_y;
    m_zx   = in_src_z * in_dst_x;
    m_xz   = in_src_x * in_dst_z;
    m_xy   = in_src_x * in_dst_y;
    m_yx   = in_src_y * in_dst_x;
    m_xx   = in_src_x * in_dst_x;
    m_yy   = in_src_y * in_dst_y;
    m_zz   = in_src_z * in_dst_z;
    cx_nxt = {m_yz[31], m_yz} - {m_zy[31], m_zy};
    cy_nxt = {m_zx[31], m_zx} - {m_xz[31], m_xz};
    cz_nxt = {m_xy[31], m_xy} - {m_yx[31], m_yx};
    p_nxt  = {{2{m_xx[31]}}, m_xx} + {{2{m_yy[31]}}, m_yy} + {{2{m_zz[31]}}, m_zz};
  end

  // stage S2: clamp dot product, magnitudes
  logic signed [63:0] pe, pc;
  logic [63:0]        pabs, p30m;
  logic [2:0][31:0]   ca_nxt;
  logic signed [32:0] cneg [3];
  logic signed [32:0] cval [3];

  always_comb begin
    pe   = {{30{p_r[33]}}, p_r};
    pc   = (pe > ONE2) ? ONE2 : ((pe < -ONE2) ? -ONE2 : pe);
    pabs = pc[63] ? 64'(-pc) : 64'(pc);
    p30m = (pabs >> PSH_R) << PSH_L;
    cval[0] = cx_r;
    cval[1] = cy_r;
    cval[2] = cz_r;
    for (int i = 0; i < 3; i++) begin
      cneg[i]   = -cval[i];
      ca_nxt[i] = cval[i][32] ? cneg[i][31:0] : cval[i][31:0];
    end
  end

  // stage S3: squares
  logic [61:0] pp_nxt, pp_r;
  logic [63:0] cc_nxt [3];
  logic [63:0] cc_r [3];

  always_comb begin
    pp_nxt = side_r[ST_S2].pa * side_r[ST_S2].pa;
    for (int i = 0; i < 3; i++) begin
      cc_nxt[i] = side_r[ST_S2].ca[i] * side_r[ST_S2].ca[i];
    end
  end

  // stage S4: radicands
  wide_t rs_nxt, rn_nxt, rs_r, rn_r;
  assign rs_nxt = (64'd1 << 60) - 64'(pp_r);
  assign rn_nxt = cc_r[0] + cc_r[1] + cc_r[2];

  // root chain A: sine of the dot angle and cross-product norm
  wide_t sas_v [SQ_CELLS+1];
  wide_t sas_r [SQ_CELLS+1];
  wide_t san_v [SQ_CELLS+1];
  wide_t san_r [SQ_CELLS+1];
  assign sas_v[0] = rs_r;
  assign sas_r[0] = '0;
  assign san_v[0] = rn_r;
  assign san_r[0] = '0;

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqa
    qftv_sqrt_cell u_s (
      .clk(clk), .en(adv), .j(idx_t'(SQ_CELLS - 1 - g)),
      .v_i(sas_v[g]), .r_i(sas_r[g]), .v_o(sas_v[g+1]), .r_o(sas_r[g+1])
    );
    qftv_sqrt_cell u_n (
      .clk(clk), .en(adv), .j(idx_t'(SQ_CELLS - 1 - g)),
      .v_i(san_v[g]), .r_i(san_r[g]), .v_o(san_v[g+1]), .r_o(san_r[g+1])
    );
  end

  // vectoring then rotation CORDIC
  xy_t  cv_x [CORDIC_STAGES+1];
  xy_t  cv_y [CORDIC_STAGES+1];
  ang_t cv_z [CORDIC_STAGES+1];
  xy_t  cr_x [CORDIC_STAGES+1];
  xy_t  cr_y [CORDIC_STAGES+1];
  ang_t cr_z [CORDIC_STAGES+1];
  xy_t  s30x, pax;

  assign s30x    = {3'b000, sas_r[SQ_CELLS][30:0]};
  assign pax     = {3'b000, side_r[VEC0-1].pa};
  assign cv_x[0] = side_r[VEC0-1].psgn ? s30x : pax;
  assign cv_y[0] = side_r[VEC0-1].psgn ? pax : s30x;
  assign cv_z[0] = side_r[VEC0-1].psgn ? HALF_PI_Q30 : '0;

  assign cr_x[0] = 34'sh0_4000_0000;
  assign cr_y[0] = '0;
  assign cr_z[0] = cv_z[CORDIC_STAGES] >>> 1;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    qftv_cordic_cell u_v (
      .clk(clk), .en(adv), .rot(1'b0), .k(idx_t'(g)),
      .x_i(cv_x[g]), .y_i(cv_y[g]), .z_i(cv_z[g]),
      .x_o(cv_x[g+1]), .y_o(cv_y[g+1]), .z_o(cv_z[g+1])
    );
    qftv_cordic_cell u_r (
      .clk(clk), .en(adv), .rot(1'b1), .k(idx_t'(g)),
      .x_i(cr_x[g]), .y_i(cr_y[g]), .z_i(cr_z[g]),
      .x_o(cr_x[g+1]), .y_o(cr_y[g+1]), .z_o(cr_z[g+1])
    );
  end

  // stages M1..M3: magnitude of the rotated vector
  xy_t         rxn, ryn;
  logic [31:0] ax_nxt, ay_nxt;
  wide_t       sqx_nxt, sqy_nxt, sqx_r, sqy_r, ms_nxt, ms_r;

  always_comb begin
    rxn     = -cr_x[CORDIC_STAGES];
    ryn     = -cr_y[CORDIC_STAGES];
    ax_nxt  = cr_x[CORDIC_STAGES][XW-1] ? rxn[31:0] : cr_x[CORDIC_STAGES][31:0];
    ay_nxt  = cr_y[CORDIC_STAGES][XW-1] ? ryn[31:0] : cr_y[CORDIC_STAGES][31:0];
    sqx_nxt = side_r[ST_M1].ax * side_r[ST_M1].ax;
    sqy_nxt = side_r[ST_M1].ay * side_r[ST_M1].ay;
    ms_nxt  = sqx_r + sqy_r;
  end

  // root chain B
  wide_t sb_v [SQ_CELLS+1];
  wide_t sb_r [SQ_CELLS+1];
  assign sb_v[0] = ms_r;
  assign sb_r[0] = '0;

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqb
    qftv_sqrt_cell u_m (
      .clk(clk), .en(adv), .j(idx_t'(SQ_CELLS - 1 - g)),
      .v_i(sb_v[g]), .r_i(sb_r[g]), .v_o(sb_v[g+1]), .r_o(sb_r[g+1])
    );
  end

  // stage D0: rounded numerators over the magnitude
  logic [31:0] mag;
  wide_t       nw_nxt, ns_nxt, dm_nxt, nw_r, ns_r, dm_r;

  always_comb begin
    mag    = (sb_r[SQ_CELLS][31:0] == 32'd0) ? 32'd1 : sb_r[SQ_CELLS][31:0];
    dm_nxt = 64'(mag);
    nw_nxt = (64'(side_r[ST_D0-1].ax) << FRAC_BITS) + 64'(mag >> 1);
    ns_nxt = (64'(side_r[ST_D0-1].ay) << 30) + 64'(mag >> 1);
  end

  // divider chain C: w and sine
  wide_t cw_rem [DIV_CELLS+1];
  wide_t cw_den [DIV_CELLS+1];
  quo_t  cw_q   [DIV_CELLS+1];
  wide_t cs_rem [DIV_CELLS+1];
  wide_t cs_den [DIV_CELLS+1];
  quo_t  cs_q   [DIV_CELLS+1];
  assign cw_rem[0] = nw_r;
  assign cw_den[0] = dm_r;
  assign cw_q[0]   = '0;
  assign cs_rem[0] = ns_r;
  assign cs_den[0] = dm_r;
  assign cs_q[0]   = '0;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_divc
    qftv_div_cell u_w (
      .clk(clk), .en(adv), .j(idx_t'(DIV_CELLS - 1 - g)),
      .rem_i(cw_rem[g]), .den_i(cw_den[g]), .q_i(cw_q[g]),
      .rem_o(cw_rem[g+1]), .den_o(cw_den[g+1]), .q_o(cw_q[g+1])
    );
    qftv_div_cell u_s (
      .clk(clk), .en(adv), .j(idx_t'(DIV_CELLS - 1 - g)),
      .rem_i(cs_rem[g]), .den_i(cs_den[g]), .q_i(cs_q[g]),
      .rem_o(cs_rem[g+1]), .den_o(cs_den[g+1]), .q_o(cs_q[g+1])
    );
  end

  // stages E1, E2: axis numerators
  wide_t prod_nxt [3];
  wide_t prod_r   [3];
  wide_t an_nxt   [3];
  wide_t an_r     [3];
  wide_t den_nxt, den_r;

  always_comb begin
    den_nxt = 64'(side_r[ST_E1].norm) << (30 - FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = side_r[ST_E1-1].ca[i] * cs_q[DIV_CELLS];
      an_nxt[i]   = prod_r[i] + (den_nxt >> 1);
    end
  end

  // divider chain D: axis components
  wide_t d_rem [3][DIV_CELLS+1];
  wide_t d_den [3][DIV_CELLS+1];
  quo_t  d_q   [3][DIV_CELLS+1];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign d_rem[a][0] = an_r[a];
    assign d_den[a][0] = den_r;
    assign d_q[a][0]   = '0;
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_divd
      qftv_div_cell u_d (
        .clk(clk), .en(adv), .j(idx_t'(DIV_CELLS - 1 - g)),
        .rem_i(d_rem[a][g]), .den_i(d_den[a][g]), .q_i(d_q[a][g]),
        .rem_o(d_rem[a][g+1]), .den_o(d_den[a][g+1]), .q_o(d_q[a][g+1])
      );
    end
  end

  // sideband alignment
  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_valid};
    for (int i = 1; i < DEPTH; i++) begin
      side_nxt[i] = side_r[i-1];
    end
    side_nxt[ST_S1]    = '0;
    side_nxt[ST_S1].eq = (in_src_x == in_dst_x) && (in_src_y == in_dst_y) &&
                         (in_src_z == in_dst_z);
    for (int i = 0; i < 3; i++) begin
      side_nxt[ST_S2].csgn[i] = cval[i][32];
    end
    side_nxt[ST_S2].ca     = ca_nxt;
    side_nxt[ST_S2].pa     = p30m[30:0];
    side_nxt[ST_S2].psgn   = pc[63] && (p30m[30:0] != 31'd0);
    side_nxt[VEC0].norm    = san_r[SQ_CELLS][31:0];
    side_nxt[ST_M1].xsgn   = cr_x[CORDIC_STAGES][XW-1];
    side_nxt[ST_M1].ysgn   = cr_y[CORDIC_STAGES][XW-1];
    side_nxt[ST_M1].ax     = ax_nxt;
    side_nxt[ST_M1].ay     = ay_nxt;
    side_nxt[ST_E1].w      = sat16(cw_q[DIV_CELLS], side_r[ST_E1-1].xsgn);
  end

  // output assembly
  logic [15:0] ow_nxt, ox_nxt, oy_nxt, oz_nxt;
  logic [1:0]  os_nxt;
  logic [15:0] ow_r, ox_r, oy_r, oz_r;
  logic [1:0]  os_r;
  side_t       sd;

  always_comb begin
    sd = side_r[ST_OUT-1];
    if (sd.eq) begin
      ow_nxt = W_ONE;
      ox_nxt = '0;
      oy_nxt = '0;
      oz_nxt = '0;
      os_nxt = ST_IDENT;
    end else if (sd.norm == 32'd0) begin
      ow_nxt = sd.w;
      ox_nxt = '0;
      oy_nxt = '0;
      oz_nxt = '0;
      os_nxt = ST_DEGEN;
    end else begin
      ow_nxt = sd.w;
      ox_nxt = sat16(d_q[0][DIV_CELLS], sd.csgn[0] ^ sd.ysgn);
      oy_nxt = sat16(d_q[1][DIV_CELLS], sd.csgn[1] ^ sd.ysgn);
      oz_nxt = sat16(d_q[2][DIV_CELLS], sd.csgn[2] ^ sd.ysgn);
      os_nxt = ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cz_r   <= cz_nxt;
      p_r    <= p_nxt;
      pp_r   <= pp_nxt;
      cc_r   <= cc_nxt;
      rs_r   <= rs_nxt;
      rn_r   <= rn_nxt;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      ms_r   <= ms_nxt;
      nw_r   <= nw_nxt;
      ns_r   <= ns_nxt;
      dm_r   <= dm_nxt;
      prod_r <= prod_nxt;
      an_r   <= an_nxt;
      den_r  <= den_nxt;
      ow_r   <= ow_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      os_r   <= os_nxt;
    end
  end

  assign out_valid  = vld_r[ST_OUT];
  assign out_quat_w = ow_r;
  assign out_quat_x = ox_r;
  assign out_quat_y = oy_r;
  assign out_quat_z = oz_r;
  assign out_status = os_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[ST_S1])
    else $error("accepted item missing from first stage");

  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("chain advanced while result held");

  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_IDENT) |->
      (out_quat_w == W_ONE && out_quat_x == 16'sd0 &&
       out_quat_y == 16'sd0 && out_quat_z == 16'sd0))
    else $error("identity result malformed");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DEGEN) |->
      (out_quat_x == 16'sd0 && out_quat_y == 16'sd0 && out_quat_z == 16'sd0))
    else $error("degenerate result has nonzero axis");

endmodule

`default_nettype wire

// ===== test/quaternion_from_two_vectors_unit_test.sv =====
// Self-checking bench for the shortest-arc quaternion unit: drives vector pairs
// through the valid/stall channels and compares each result with an in-bench
// fixed-point model. Depends on qftv_pkg and quaternion_from_two_vectors_unit.
`default_nettype none

module quaternion_from_two_vectors_unit_test;
  import qftv_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int NSTG = CORDIC_STAGES;
  localparam int LATENCY = 171;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    status_t st;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_src_x = '0, in_src_y = '0, in_src_z = '0;
  logic signed [15:0] in_dst_x = '0, in_dst_y = '0, in_dst_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic [1:0] out_status;

  quat_t expected_quats[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  bit failed = 1'b0;

  quaternion_from_two_vectors_unit dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_src_x, .in_src_y, .in_src_z, .in_dst_x, .in_dst_y, .in_dst_z,
    .out_valid, .out_stall, .out_quat_w, .out_quat_x, .out_quat_y, .out_quat_z,
    .out_status
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_div(input longint n, input longint d);
    longint unsigned a, q;
    a = (n < 0) ? -n : n;
    q = (a + longint'(d) / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint atan_step(input int k);
    return longint'(atan_q30(idx_t'(k)));
  endfunction

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic quat_t arc_quaternion(input longint sx, sy, sz, dx, dy, dz);
    quat_t q;
    longint cx, cy, cz, p, one2, p30, x, y, z, nx, ny, s30, half, den;
    longint unsigned mag, nrm;
    q = '0;
    if (sx == dx && sy == dy && sz == dz) begin
      q.w = W_ONE;
      q.st = ST_IDENT;
      return q;
    end
    cx = sy * dz - sz * dy;
    cy = sz * dx - sx * dz;
    cz = sx * dy - sy * dx;
    p = sx * dx + sy * dy + sz * dz;
    one2 = 64'sd1 << (2 * F);
    if (p > one2) p = one2;
    if (p < -one2) p = -one2;
    p30 = abs64(p) << (30 - 2 * F);
    if (p < 0) p30 = -p30;
    s30 = int_sqrt((64'd1 << 60) - abs64(p30) * abs64(p30));
    if (p30 < 0) begin
      x = s30; y = -p30; z = HALF_PI_Q30;
    end else begin
      x = p30; y = s30; z = 0;
    end
    for (int i = 0; i < NSTG; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
      end
      x = nx; y = ny;
    end
    half = z >>> 1;
    x = 64'sd1 << 30; y = 0; z = half;
    for (int i = 0; i < NSTG; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
      end
      x = nx; y = ny;
    end
    mag = int_sqrt(abs64(x) * abs64(x) + abs64(y) * abs64(y));
    if (mag == 0) mag = 1;
    q.w = clip16(round_div(x * (64'sd1 << F), mag));
    s30 = round_div(y * (64'sd1 << 30), mag);
    nrm = int_sqrt(abs64(cx) * abs64(cx) + abs64(cy) * abs64(cy) + abs64(cz) * abs64(cz));
    if (nrm == 0) begin
      q.st = ST_DEGEN;
      return q;
    end
    den = nrm << (30 - F);
    q.x = clip16(round_div(cx * s30, den));
    q.y = clip16(round_div(cy * s30, den));
    q.z = clip16(round_div(cz * s30, den));
    q.st = ST_NORMAL;
    return q;
  endfunction

  task automatic send_pair(input logic signed [15:0] sx, sy, sz, dx, dy, dz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_x <= sx; in_src_y <= sy; in_src_z <= sz;
    in_dst_x <= dx; in_dst_y <= dy; in_dst_z <= dz;
    do @(posedge clk); while (in_stall);
    expected_quats.push_back(arc_quaternion(sx, sy, sz, dx, dy, dz));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d st=%0d", $time,
                   out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_status);
          failed = 1'b1;
        end else begin
          quat_t e;
          e = expected_quats.pop_front();
          if (out_quat_w !== e.w || out_quat_x !== e.x || out_quat_y !== e.y ||
              out_quat_z !== e.z || out_status !== e.st) begin
            $display("%0t: expected w=%0d x=%0d y=%0d z=%0d st=%0d", $time,
                     e.w, e.x, e.y, e.z, e.st);
            $display("%0t: actual   w=%0d x=%0d y=%0d z=%0d st=%0d", $time,
                     out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_status);
            failed = 1'b1;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_unitish(input bit same, input bit anti);
    logic signed [15:0] a, b, c;
    int m;
    m = $urandom_range(2);
    a = 16'($urandom_range(32768) - 16384);
    b = 16'($urandom_range(32768) - 16384);
    c = 16'($urandom_range(32768) - 16384);
    if (m == 0) send_pair(a, b, c, rand_comp(), rand_comp(), rand_comp());
    else if (same) send_pair(a, b, c, a, b, c);
    else if (anti) send_pair(a, b, c, -a, -b, -c);
    else send_pair(a, b, c, 16'($urandom_range(32768) - 16384),
                   16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384));
  endtask

  task automatic test_directed();
    send_pair(16384, 0, 0, 16384, 0, 0);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(16384, 0, 0, 0, 16384, 0);
    send_pair(0, 16384, 0, 0, 0, 16384);
    send_pair(0, 0, 16384, 16384, 0, 0);
    send_pair(16384, 0, 0, -16384, 0, 0);
    send_pair(16384, 0, 0, 8192, 0, 0);
    send_pair(0, 0, 0, 16384, 0, 0);
    send_pair(0, 0, 0, 0, 0, 1);
    send_pair(32767, 32767, 32767, -32768, -32768, -32768);
    send_pair(32767, -32768, 32767, -32768, 32767, -32768);
    send_pair(32767, 0, 0, 0, 32767, 0);
    send_pair(-32768, 0, 0, 0, -32768, 0);
    send_pair(11585, 11585, 0, 11585, -11585, 0);
    send_pair(16384, 0, 0, 16383, 181, 0);
    send_pair(16384, 0, 0, 16384, 1, 0);
    send_pair(9459, 9459, 9459, -9459, -9459, -9459);
    send_pair(1, 2, 3, 3, 2, 1);
    send_pair(-1, -1, -1, 1, 1, 1);
    send_pair(32767, 32767, 32767, 32767, 32767, -32768);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_unitish($urandom_range(9) == 0, $urandom_range(9) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 33; recv_idle_pct = 82;
    test_directed();
    test_random(440);
    send_idle_pct = 82; recv_idle_pct = 33;
    test_random(440);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(500);
    drain();
    if (!failed && expected_quats.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
